/* rtl/int_to_ascii_radix_defines.svh */
// shared assertion macros for the int_to_ascii_radix checker
`ifndef INT_TO_ASCII_RADIX_DEFINES_SVH
`define INT_TO_ASCII_RADIX_DEFINES_SVH

// same-cycle implication, quiet while reset is asserted
`define ITOA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet while reset is asserted
`define ITOA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/itoa_pkg.sv */
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types, constants and the digit-to-character map of the
// integer-to-text converter.
// ----------------------------------------------------------------------------
`default_nettype none

package itoa_pkg;

    localparam int unsigned RADIX_W    = 6;
    localparam int unsigned CHAR_W     = 8;
    localparam int unsigned ADDR_W     = 2;
    localparam int unsigned APB_DATA_W = 32;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd35;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [CHAR_W-1:0]  SIGN_CHAR   = 8'h2D;
    localparam logic [ADDR_W-1:0]  RADIX_ADDR  = 2'd0;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_SIGN = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    typedef struct packed {
        logic done;
        logic quot_zero;
    } div_status_t;

    // digits 0..9 map to '0'..'9', 10 and above to 'a'...
    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] d_ext;
        d_ext = {{(CHAR_W-RADIX_W){1'b0}}, d};
        if (d < 6'd10)
            digit_char = 8'h30 + d_ext;
        else
            digit_char = 8'h57 + d_ext;
    endfunction

endpackage

`default_nettype wire

/* rtl/int_to_ascii_radix.sv */
// ----------------------------------------------------------------------------
// int_to_ascii_radix
// Signed integer to ASCII text in a programmable base, one character a cycle.
// ----------------------------------------------------------------------------
// A transaction starts when start is high while busy is low. With a valid
// radix (2..35) the digits are produced least significant first by a
// bit-serial divider, then sent out most significant first, a '-' ahead of
// negative numbers, one character per cycle on consecutive cycles;
// last_char marks the final one. The final character's strobe comes in the
// first cycle with busy low. The strobe cannot be held off, so the receiver
// must take every character in the cycle it appears. With an invalid radix
// a single result with empty_text and last_char set comes out the cycle
// after start, and busy stays low. The radix register is at byte address 0.
// ----------------------------------------------------------------------------
`default_nettype none

module int_to_ascii_radix
    import itoa_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ADDR_W-1:0]             paddr,
    input  wire logic [APB_DATA_W-1:0]         pwdata,
    output logic      [APB_DATA_W-1:0]         prdata,
    output logic                               pready,
    input  wire logic                          start,
    input  wire logic signed [VALUE_WIDTH-1:0] number,
    output logic                               busy,
    output logic                               strobe,
    output logic [CHAR_W-1:0]                  char_code,
    output logic                               last_char,
    output logic                               empty_text
);

    localparam int unsigned BUF_DEPTH = VALUE_WIDTH + 1;
    localparam int unsigned IDX_W     = $clog2(BUF_DEPTH);
    localparam int unsigned CNT_W     = $clog2(BUF_DEPTH + 1);

    state_t state_reg, state_next;

    logic [RADIX_W-1:0] radix_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic               neg_reg;
    logic [CHAR_W-1:0]  digit_buf_reg [BUF_DEPTH];

    logic               strobe_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic               last_reg;
    logic               empty_reg;

    logic                   accept;
    logic                   radix_ok;
    logic                   cfg_write;
    logic                   div_load;
    logic [VALUE_WIDTH-1:0] div_dividend;
    logic [VALUE_WIDTH-1:0] magnitude;
    logic [VALUE_WIDTH-1:0] quotient;
    logic [RADIX_W-1:0]     remainder;
    div_status_t            div_status;

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign radix_ok  = (radix_reg >= RADIX_MIN) && (radix_reg <= RADIX_MAX);
    assign cfg_write = psel && penable && pwrite && (paddr == RADIX_ADDR);

    // unsigned negation so the most negative value keeps its magnitude
    assign magnitude = number[VALUE_WIDTH-1] ? VALUE_WIDTH'(~number + 1'b1)
                                             : VALUE_WIDTH'(number);

    assign div_load     = (accept && radix_ok)
                       || ((state_reg == ST_DIV) && div_status.done && !div_status.quot_zero);
    assign div_dividend = accept ? magnitude : quotient;

    itoa_div_unit #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (div_load),
        .dividend (div_dividend),
        .divisor  (radix_reg),
        .status   (div_status),
        .quotient (quotient),
        .remainder(remainder)
    );

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr == RADIX_ADDR)
                  ? {{(APB_DATA_W-RADIX_W){1'b0}}, radix_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radix_reg <= RADIX_RESET;
        else if (cfg_write)
            radix_reg <= pwdata[RADIX_W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && radix_ok)
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_status.done && div_status.quot_zero)
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
            end
            ST_SIGN:
                state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (idx_reg == '0)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
            count_reg  <= '0;
            idx_reg    <= '0;
            neg_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= (accept && !radix_ok)
                       || (state_reg == ST_SIGN) || (state_reg == ST_EMIT);
            if (accept && radix_ok)
            begin
                count_reg <= '0;
                neg_reg   <= number[VALUE_WIDTH-1];
            end
            else if ((state_reg == ST_DIV) && div_status.done)
            begin
                count_reg <= count_reg + 1'b1;
                // last digit stored: start reading back from it
                if (div_status.quot_zero)
                    idx_reg <= count_reg[IDX_W-1:0];
            end
            else if (state_reg == ST_EMIT)
                idx_reg <= idx_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_DIV) && div_status.done)
            digit_buf_reg[count_reg[IDX_W-1:0]] <= digit_char(remainder);
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (accept && !radix_ok)
        begin
            char_reg  <= '0;
            last_reg  <= 1'b1;
            empty_reg <= 1'b1;
        end
        else if (state_reg == ST_SIGN)
        begin
            char_reg  <= SIGN_CHAR;
            last_reg  <= 1'b0;
            empty_reg <= 1'b0;
        end
        else if (state_reg == ST_EMIT)
        begin
            char_reg  <= digit_buf_reg[idx_reg];
            last_reg  <= (idx_reg == '0);
            empty_reg <= 1'b0;
        end
    end

    assign strobe     = strobe_reg;
    assign char_code  = char_reg;
    assign last_char  = last_reg;
    assign empty_text = empty_reg;

endmodule

`default_nettype wire

/* rtl/itoa_div_unit.sv */
// ----------------------------------------------------------------------------
// itoa_div_unit
// Bit-serial restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module itoa_div_unit
    import itoa_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   load,
    input  wire logic [VALUE_WIDTH-1:0] dividend,
    input  wire logic [RADIX_W-1:0]     divisor,
    output div_status_t                 status,
    output logic [VALUE_WIDTH-1:0]      quotient,
    output logic [RADIX_W-1:0]          remainder
);

    localparam int unsigned BIT_CNT_W = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
    localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(VALUE_WIDTH - 1);

    logic [VALUE_WIDTH-1:0] q_reg, q_next;
    logic [RADIX_W-1:0]     r_reg, r_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg;
    logic                   run_reg;
    div_status_t            status_reg;

    logic [RADIX_W:0] r_shift;
    logic             fits;

    // shift in the next dividend bit, subtract the divisor where it fits
    always_comb
    begin
        r_shift = {r_reg, q_reg[VALUE_WIDTH-1]};
        fits    = (r_shift >= {1'b0, divisor});
        r_next  = fits ? RADIX_W'(r_shift - {1'b0, divisor}) : r_shift[RADIX_W-1:0];
        q_next  = {q_reg[VALUE_WIDTH-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg     <= 1'b0;
            bit_cnt_reg <= '0;
            status_reg  <= '0;
        end
        else
        begin
            status_reg.done <= 1'b0;
            if (load)
            begin
                run_reg     <= 1'b1;
                bit_cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                bit_cnt_reg <= bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == LAST_BIT)
                begin
                    run_reg              <= 1'b0;
                    status_reg.done      <= 1'b1;
                    status_reg.quot_zero <= (q_next == '0);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            q_reg <= dividend;
            r_reg <= '0;
        end
        else if (run_reg)
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign status    = status_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

`default_nettype wire

/* rtl/itoa_checker.sv */
// ----------------------------------------------------------------------------
// itoa_checker
// Port-level checks of the converter's result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "int_to_ascii_radix_defines.svh"

module itoa_checker
    import itoa_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              strobe,
    input wire logic [CHAR_W-1:0] char_code,
    input wire logic              last_char,
    input wire logic              empty_text
);

    // characters of one number come on back-to-back cycles
    `ITOA_ASSERT_NEXT(a_text_contiguous, strobe && !last_char, strobe, "text broke off before last character")

    // while a number is still going out no new transaction may start
    `ITOA_ASSERT_NOW(a_busy_during_text, strobe && !last_char, busy, "busy low in the middle of a number")

    // an empty result stands alone and carries no character
    `ITOA_ASSERT_NOW(a_empty_alone, strobe && empty_text, last_char && (char_code == '0), "empty result malformed")

    // a sign is never the final character
    `ITOA_ASSERT_NOW(a_sign_not_last, strobe && !empty_text && (char_code == SIGN_CHAR), !last_char, "sign emitted as last character")

endmodule

bind int_to_ascii_radix itoa_checker u_itoa_checker (.*);

`default_nettype wire

/* tb/int_to_ascii_radix_checker.sv */
// ----------------------------------------------------------------------------
// int_to_ascii_radix_checker
// Watches the register port, the number transactions and the character
// stream of the converter, predicts the text of every accepted number and
// compares each character field by field, oldest prediction first.
// ----------------------------------------------------------------------------
module int_to_ascii_radix_checker
    import itoa_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ADDR_W-1:0]             paddr,
    input  logic [APB_DATA_W-1:0]         pwdata,
    input  logic [APB_DATA_W-1:0]         prdata,
    input  logic                          pready,
    input  logic                          start,
    input  logic signed [VALUE_WIDTH-1:0] number,
    input  logic                          busy,
    input  logic                          strobe,
    input  logic [CHAR_W-1:0]             char_code,
    input  logic                          last_char,
    input  logic                          empty_text,
    output int unsigned                   failures,
    output int unsigned                   pending,
    output int unsigned                   chars_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last_char;
        logic              empty_text;
    } text_char_t;

    logic [RADIX_W-1:0] radix_q;
    text_char_t         expected_text [$];

    // builds the text of one number, most significant character first
    function automatic void queue_text(input logic [VALUE_WIDTH-1:0] value,
                                       input logic [RADIX_W-1:0] base);
        logic [VALUE_WIDTH-1:0] magnitude;
        logic [CHAR_W-1:0]      digits [$];
        int unsigned            rest;
        int unsigned            digit;
        if (base < RADIX_MIN || base > RADIX_MAX) begin
            expected_text.push_back('{'0, 1'b1, 1'b1});
            return;
        end
        // unsigned magnitude, so the most negative value needs no special path
        magnitude = value[VALUE_WIDTH-1] ? ~value + 1'b1 : value;
        rest = magnitude;
        do
        begin
            digit = rest % base;
            if (digit < 10)
                digits.push_front(CHAR_W'("0") + CHAR_W'(digit));
            else
                digits.push_front(CHAR_W'("a") + CHAR_W'(digit - 10));
            rest = rest / base;
        end
        while (rest != 0);
        if (value[VALUE_WIDTH-1])
            expected_text.push_back('{SIGN_CHAR, 1'b0, 1'b0});
        foreach (digits[i])
            expected_text.push_back('{digits[i], i == digits.size() - 1, 1'b0});
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        text_char_t want;
        if (!rst_n)
        begin
            radix_q <= RADIX_RESET;
            expected_text.delete();
            failures = 0;
            pending = 0;
            chars_checked = 0;
        end
        else
        begin
            if (strobe)
            begin
                chars_checked++;
                if (expected_text.size() == 0)
                begin
                    $error("character 0x%02h with no transaction waiting", char_code);
                    failures++;
                end
                else
                begin
                    want = expected_text.pop_front();
                    if (char_code !== want.char_code)
                    begin
                        $error("char_code expected 0x%02h actual 0x%02h",
                               want.char_code, char_code);
                        failures++;
                    end
                    if (last_char !== want.last_char)
                    begin
                        $error("last_char expected %0b actual %0b", want.last_char, last_char);
                        failures++;
                    end
                    if (empty_text !== want.empty_text)
                    begin
                        $error("empty_text expected %0b actual %0b",
                               want.empty_text, empty_text);
                        failures++;
                    end
                end
            end
            if (start && !busy)
                queue_text(number, radix_q);
            if (psel && penable && pready && paddr == RADIX_ADDR)
            begin
                if (pwrite)
                    radix_q <= pwdata[RADIX_W-1:0];
                else if (prdata[RADIX_W-1:0] !== radix_q)
                begin
                    $error("radix expected %0d actual %0d", radix_q, prdata[RADIX_W-1:0]);
                    failures++;
                end
            end
            pending = expected_text.size();
        end
    end

endmodule

/* tb/int_to_ascii_radix_tb.sv */
// ----------------------------------------------------------------------------
// int_to_ascii_radix_tb
// Drives numbers and radix settings into the integer-to-text converter:
// directed extremes in every kind of base, then random numbers, some aimed at
// digit-count boundaries, with random gaps, and gives the verdict.
// ----------------------------------------------------------------------------
module int_to_ascii_radix_tb;
    import itoa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned VALUE_WIDTH = 16;
    localparam int unsigned ROUNDS      = 10;
    localparam int unsigned ROUND_ITEMS = 26;
    localparam int unsigned MAX_GAP     = 17;
    // slowest number: sixteen binary digits plus sign
    localparam int unsigned SETTLE      = 320;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [ADDR_W-1:0]             paddr = RADIX_ADDR;
    logic [APB_DATA_W-1:0]         pwdata = '0;
    logic [APB_DATA_W-1:0]         prdata;
    logic                          pready;
    logic                          start = 1'b0;
    logic signed [VALUE_WIDTH-1:0] number = '0;
    logic                          busy;
    logic                          strobe;
    logic [CHAR_W-1:0]             char_code;
    logic                          last_char;
    logic                          empty_text;

    int unsigned failures;
    int unsigned pending;
    int unsigned chars_checked;
    int unsigned numbers_sent = 0;
    int unsigned radix_settings = 1;
    logic [RADIX_W-1:0] radix_now = RADIX_RESET;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    int_to_ascii_radix #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .start      (start),
        .number     (number),
        .busy       (busy),
        .strobe     (strobe),
        .char_code  (char_code),
        .last_char  (last_char),
        .empty_text (empty_text)
    );

    int_to_ascii_radix_checker #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .start         (start),
        .number        (number),
        .busy          (busy),
        .strobe        (strobe),
        .char_code     (char_code),
        .last_char     (last_char),
        .empty_text    (empty_text),
        .failures      (failures),
        .pending       (pending),
        .chars_checked (chars_checked)
    );

    task automatic send_number(input logic signed [VALUE_WIDTH-1:0] value,
                               input int unsigned max_gap);
        int unsigned gap;
        gap = $urandom_range(0, max_gap);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        number <= value;
        @(posedge clk);
        while (busy) @(posedge clk);
        numbers_sent++;
    endtask

    // hold off until every character of the numbers in flight has come out
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0 || busy) @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic apb_access(input logic write, input logic [APB_DATA_W-1:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= write;
        paddr <= RADIX_ADDR;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_radix(input logic [RADIX_W-1:0] base);
        logic [APB_DATA_W-1:0] data;
        data = $urandom();
        data[RADIX_W-1:0] = base;
        drain();
        apb_access(1'b1, data);
        apb_access(1'b0, '0);
        radix_now = base;
        radix_settings++;
    endtask

    // values next to a power of the base, where the digit count changes, small values, extremes and random values
    function automatic logic [VALUE_WIDTH-1:0] pick_number(input logic [RADIX_W-1:0] base);
        int unsigned kind;
        int unsigned steps;
        int          power;
        int          value;
        kind = $urandom_range(0, 9);
        value = $urandom();
        if (kind >= 4 && kind <= 5)
            value = int'($urandom_range(0, 80)) - 40;
        else if (kind >= 6 && kind <= 7 && base >= 2)
        begin
            power = 1;
            steps = $urandom_range(1, 15);
            while (steps > 0 && power * base <= 32768)
            begin
                power = power * base;
                steps--;
            end
            value = power - int'($urandom_range(0, 1));
            if ($urandom_range(0, 1))
                value = -value;
        end
        else if (kind == 8)
        begin
            case ($urandom_range(0, 3))
                0: value = -32768;
                1: value = 32767;
                2: value = 0;
                default: value = -1;
            endcase
        end
        return value[VALUE_WIDTH-1:0];
    endfunction

    initial
    begin
        int unsigned max_gap;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // reset radix, then the extremes of the base range and invalid bases
        send_number(16'sd0, MAX_GAP);
        send_number(16'sd1, MAX_GAP);
        send_number(-16'sd1, MAX_GAP);
        send_number(16'sd32767, MAX_GAP);
        send_number(-16'sd32768, MAX_GAP);
        set_radix(RADIX_MIN);
        send_number(-16'sd32768, MAX_GAP);
        send_number(16'sd32767, MAX_GAP);
        set_radix(RADIX_MAX);
        send_number(16'sd34, MAX_GAP);
        send_number(16'sd35, MAX_GAP);
        send_number(-16'sd32768, MAX_GAP);
        set_radix(6'd16);
        send_number(16'h7bcd, MAX_GAP);
        send_number(16'h8001, MAX_GAP);
        set_radix(6'd0);
        send_number(16'sd5, MAX_GAP);
        send_number(16'sd7, 0);
        set_radix(6'd1);
        send_number(16'sd1, MAX_GAP);
        set_radix(6'd36);
        send_number(-16'sd1, MAX_GAP);
        set_radix(6'd63);
        send_number(16'sd0, MAX_GAP);
        send_number(-16'sd32768, 0);

        for (int unsigned round = 0; round < ROUNDS; round++)
        begin
            if (round == 0)
                set_radix(RADIX_MIN);
            else if (round == 1)
                set_radix(RADIX_MAX);
            else if ($urandom_range(0, 7) == 0)
                set_radix(RADIX_W'($urandom_range(0, 1) ? $urandom_range(0, 1)
                                                        : $urandom_range(36, 63)));
            else
                set_radix(RADIX_W'($urandom_range(2, 35)));
            // some rounds run back to back
            max_gap = (round % 4 == 3) ? 0 : MAX_GAP;
            for (int unsigned i = 0; i < ROUND_ITEMS; i++)
            begin
                if (i == ROUND_ITEMS / 2 && round % 3 == 0)
                    drain();
                send_number(pick_number(radix_now), max_gap);
            end
        end

        drain();
        repeat (SETTLE) @(negedge clk);
        if (pending != 0)
            $error("%0d expected characters never came out", pending);
        $display("converted %0d numbers under %0d radix settings, %0d characters checked",
                 numbers_sent, radix_settings, chars_checked);
        if (failures == 0 && pending == 0)
            $display("int_to_ascii_radix: match");
        else
            $display("int_to_ascii_radix: mismatch");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("int_to_ascii_radix: mismatch");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/itoa_pkg.sv
rtl/itoa_div_unit.sv
rtl/int_to_ascii_radix.sv
rtl/itoa_checker.sv
tb/int_to_ascii_radix_checker.sv
tb/int_to_ascii_radix_tb.sv
